>>> rtl/core/assert_macros.svh
// assertion macros shared by the checker files
// each macro expects clk and rst_n in scope of the use site
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every sampled edge out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bprq_pkg.sv
// shared types and constants of the burst predicting ready queue
// no dependencies; imported by every module of the block
package bprq_pkg;

    localparam int MAX_THREADS  = 16;
    localparam int BURST_BITS   = 16;
    localparam int FRAC_BITS    = 8;
    localparam int ID_BITS      = 4;
    localparam int SLOT_BITS    = $clog2(MAX_THREADS);
    localparam int CNT_BITS     = $clog2(MAX_THREADS + 1);
    localparam int EST_BITS     = BURST_BITS + FRAC_BITS;
    localparam int ACC_BITS     = 32 + FRAC_BITS;
    localparam int WT_BITS      = 9;
    localparam int WT_SHIFT     = 8;
    localparam int PROD_BITS    = EST_BITS + WT_BITS;
    localparam int TOTAL_BITS   = 32;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [WT_BITS-1:0] WEIGHT_ONE   = WT_BITS'(256);
    localparam logic [WT_BITS-1:0] WEIGHT_RESET = WT_BITS'(128);

    // transaction codes
    localparam logic FUNC_READY = 1'b0;
    localparam logic FUNC_PICK  = 1'b1;

    // policy codes
    localparam logic MODE_FIFO  = 1'b0;
    localparam logic MODE_BURST = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_POLICY_MODE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTHING   = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [ID_BITS-1:0]    thread_id;
        logic [BURST_BITS-1:0] prev_burst;
    } req_t;

    typedef struct packed {
        logic [ID_BITS-1:0]    picked_thread;
        logic                  picked_valid;
        logic [EST_BITS-1:0]   new_estimate;
        logic                  dropped_full;
        logic [TOTAL_BITS-1:0] error_total;
    } rsp_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP
    } cell_op_t;

    // broadcast to every queue cell
    typedef struct packed {
        cell_op_t              op;
        logic                  by_key;
        logic [ID_BITS-1:0]    new_id;
        logic [BURST_BITS-1:0] new_key;
    } cell_ctl_t;

endpackage

>>> rtl/core/bprq_cell.sv
// one entry of the shift-register ready queue
// depends on bprq_pkg for the control struct and widths
module bprq_cell (
    input  logic                                 clk,
    input  bprq_pkg::cell_ctl_t                  ctl,
    input  logic                                 occupied,
    input  logic                                 prev_after,
    input  logic [bprq_pkg::ID_BITS-1:0]         prev_id,
    input  logic [bprq_pkg::BURST_BITS-1:0]      prev_key,
    input  logic [bprq_pkg::ID_BITS-1:0]         next_id,
    input  logic [bprq_pkg::BURST_BITS-1:0]      next_key,
    output logic [bprq_pkg::ID_BITS-1:0]         id,
    output logic [bprq_pkg::BURST_BITS-1:0]      key,
    output logic                                 after
);
    import bprq_pkg::*;

    logic [ID_BITS-1:0]    id_reg;
    logic [ID_BITS-1:0]    id_next;
    logic [BURST_BITS-1:0] key_reg;
    logic [BURST_BITS-1:0] key_next;
    logic                  gt;

    // an empty cell always sits past the insert point
    always_comb
    begin
        if (ctl.by_key)
            gt = !occupied || (key_reg > ctl.new_key);
        else
            gt = !occupied;
    end

    // insert point found here or further toward the head
    assign after = prev_after | gt;

    // take the new entry, the upstream entry, or the downstream entry
    always_comb
    begin
        id_next  = id_reg;
        key_next = key_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (prev_after)
                begin
                    id_next  = prev_id;
                    key_next = prev_key;
                end
                else if (gt)
                begin
                    id_next  = ctl.new_id;
                    key_next = ctl.new_key;
                end
            end
            CELL_POP:
            begin
                id_next  = next_id;
                key_next = next_key;
            end
            default:
            begin
                id_next  = id_reg;
                key_next = key_reg;
            end
        endcase
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        key_reg <= key_next;
    end

    assign id  = id_reg;
    assign key = key_reg;

endmodule

>>> rtl/core/bprq_est.sv
// burst estimate table, exponential average and error accumulator
// depends on bprq_pkg; three stages: table read, first product, blend
module bprq_est (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 upd,
    input  logic [bprq_pkg::SLOT_BITS-1:0]       slot,
    input  logic [bprq_pkg::BURST_BITS-1:0]      burst,
    input  logic [bprq_pkg::WT_BITS-1:0]         weight,
    output logic [bprq_pkg::EST_BITS-1:0]        est,
    output logic                                 done,
    output logic [bprq_pkg::TOTAL_BITS-1:0]      error_total
);
    import bprq_pkg::*;

    logic [EST_BITS-1:0]  table_reg [MAX_THREADS];
    logic [ACC_BITS-1:0]  acc_reg;
    logic [ACC_BITS:0]    acc_sum;
    logic [2:0]           stage_reg;

    logic [EST_BITS-1:0]  est_reg;
    logic [EST_BITS-1:0]  target_reg;
    logic [WT_BITS-1:0]   wt_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic                 upd_reg;
    logic [PROD_BITS-1:0] prod_reg;
    logic [EST_BITS-1:0]  err_reg;
    logic [EST_BITS-1:0]  result_reg;

    logic [PROD_BITS-1:0] prod_b;
    logic [PROD_BITS:0]   blend_sum;
    logic [EST_BITS-1:0]  blend;

    // second product and weighted sum, truncated after the 1/256 scale
    assign prod_b    = target_reg * wt_reg;
    assign blend_sum = {1'b0, prod_reg} + {1'b0, prod_b};
    assign blend     = blend_sum[WT_SHIFT +: EST_BITS];

    // error accumulator with saturation on carry out
    assign acc_sum = {1'b0, acc_reg} + {{(ACC_BITS + 1 - EST_BITS){1'b0}}, err_reg};

    // stage tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= '0;
        else
            stage_reg <= {stage_reg[1:0], start};
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            est_reg    <= table_reg[slot];
            target_reg <= {burst, {FRAC_BITS{1'b0}}};
            wt_reg     <= weight;
            slot_reg   <= slot;
            upd_reg    <= upd;
        end
        if (stage_reg[0])
        begin
            prod_reg <= est_reg * (WEIGHT_ONE - wt_reg);
            err_reg  <= (est_reg > target_reg) ? (est_reg - target_reg)
                                               : (target_reg - est_reg);
        end
        if (stage_reg[1])
            result_reg <= upd_reg ? blend : est_reg;
    end

    // estimate table and accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_THREADS; i++)
                table_reg[i] <= '0;
            acc_reg <= '0;
        end
        else if (stage_reg[1] && upd_reg)
        begin
            table_reg[slot_reg] <= blend;
            acc_reg <= acc_sum[ACC_BITS] ? {ACC_BITS{1'b1}} : acc_sum[ACC_BITS-1:0];
        end
    end

    assign est         = result_reg;
    assign done        = stage_reg[2];
    assign error_total = acc_reg[FRAC_BITS +: TOTAL_BITS];

endmodule

>>> rtl/core/burst_predicting_ready_queue.sv
// channel   | direction | handshake           | payload
// req       | in        | req_valid/req_stall | bprq_pkg::req_t
// rsp       | out       | rsp_valid/rsp_stall | bprq_pkg::rsp_t
// cfg       | in        | cfg_write           | cfg_index, cfg_data
//
// one transaction in flight: a pick goes from accept through S_DONE back to
// idle, a ready event first waits in S_EST for the three estimator stages
// (table read, first product, blend). a stalled rsp holds the finished result
// and the block can take one more transaction, whose result then waits for
// the rsp register. rst_n clears control, queue count, estimates and errors.
module burst_predicting_ready_queue (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  bprq_pkg::req_t                       req_data,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output bprq_pkg::rsp_t                       rsp_data,
    input  logic                                 cfg_write,
    input  logic [bprq_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [bprq_pkg::WT_BITS-1:0]         cfg_data
);
    import bprq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EST,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic                  mode_reg;
    logic [WT_BITS-1:0]    weight_reg;
    req_t                  item_reg;
    logic                  item_mode_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    logic                  req_accept;
    logic                  full;
    logic                  rsp_free;
    logic                  finish;
    logic [WT_BITS-1:0]    weight_clamped;
    logic                  est_start;
    logic                  est_upd;
    logic [EST_BITS-1:0]   est_value;
    logic                  est_done;
    logic [TOTAL_BITS-1:0] error_total;
    cell_ctl_t             ctl;
    rsp_t                  rsp_next;

    logic [ID_BITS-1:0]    cell_id    [MAX_THREADS];
    logic [BURST_BITS-1:0] cell_key   [MAX_THREADS];
    logic                  cell_after [MAX_THREADS];
    logic [MAX_THREADS-1:0] occupied;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign full       = (count_reg == CNT_BITS'(MAX_THREADS));
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign finish     = (state_reg == S_DONE) && rsp_free;

    // weights above one count as one
    assign weight_clamped = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;

    // every ready event reads the table; only burst mode with a burst and a queue that is not full updates
    assign est_start = req_accept && (req_data.func == FUNC_READY);
    assign est_upd   = (mode_reg == MODE_BURST) && (req_data.prev_burst != '0) && !full;

    bprq_est u_est (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (est_start),
        .upd         (est_upd),
        .slot        (req_data.thread_id[SLOT_BITS-1:0]),
        .burst       (req_data.prev_burst),
        .weight      (weight_clamped),
        .est         (est_value),
        .done        (est_done),
        .error_total (error_total)
    );

    // queue operation for the finishing transaction
    always_comb
    begin
        ctl.op      = CELL_HOLD;
        ctl.by_key  = (item_mode_reg == MODE_BURST);
        ctl.new_id  = item_reg.thread_id;
        ctl.new_key = (item_mode_reg == MODE_BURST) ? est_value[FRAC_BITS +: BURST_BITS]
                                                    : '0;
        if (finish)
        begin
            if (item_reg.func == FUNC_PICK)
            begin
                if (count_reg != '0)
                    ctl.op = CELL_POP;
            end
            else if (!full)
            begin
                ctl.op = CELL_INSERT;
            end
        end
    end

    // chain of queue cells, head at index zero
    genvar gi;
    generate
        for (gi = 0; gi < MAX_THREADS; gi++)
        begin : g_cell
            logic                  p_after;
            logic [ID_BITS-1:0]    p_id;
            logic [BURST_BITS-1:0] p_key;
            logic [ID_BITS-1:0]    n_id;
            logic [BURST_BITS-1:0] n_key;

            assign occupied[gi] = (CNT_BITS'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign p_after = 1'b0;
                assign p_id    = ctl.new_id;
                assign p_key   = ctl.new_key;
            end
            else
            begin : g_body
                assign p_after = cell_after[gi-1];
                assign p_id    = cell_id[gi-1];
                assign p_key   = cell_key[gi-1];
            end

            if (gi == MAX_THREADS - 1)
            begin : g_tail
                assign n_id  = cell_id[gi];
                assign n_key = cell_key[gi];
            end
            else
            begin : g_inner
                assign n_id  = cell_id[gi+1];
                assign n_key = cell_key[gi+1];
            end

            bprq_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .occupied   (occupied[gi]),
                .prev_after (p_after),
                .prev_id    (p_id),
                .prev_key   (p_key),
                .next_id    (n_id),
                .next_key   (n_key),
                .id         (cell_id[gi]),
                .key        (cell_key[gi]),
                .after      (cell_after[gi])
            );
        end
    endgenerate

    // result of the finishing transaction
    always_comb
    begin
        rsp_next               = '0;
        rsp_next.error_total   = error_total;
        if (item_reg.func == FUNC_PICK)
        begin
            if (count_reg != '0)
            begin
                rsp_next.picked_thread = cell_id[0];
                rsp_next.picked_valid  = 1'b1;
            end
        end
        else
        begin
            rsp_next.new_estimate = est_value;
            rsp_next.dropped_full = full;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_FIFO;
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_POLICY_MODE: mode_reg   <= cfg_data[0];
                REG_SMOOTHING:   weight_reg <= cfg_data;
                default:         mode_reg   <= mode_reg;
            endcase
        end
    end

    // sequencer, queue count and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_accept)
                        state_reg <= (req_data.func == FUNC_PICK) ? S_DONE : S_EST;
                end
                S_EST:
                begin
                    if (est_done)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (rsp_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (ctl.op == CELL_INSERT)
                count_reg <= count_reg + 1'b1;
            else if (ctl.op == CELL_POP)
                count_reg <= count_reg - 1'b1;

            if (finish)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    // captured transaction and result payload
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            item_reg      <= req_data;
            item_mode_reg <= mode_reg;
        end
        if (finish)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

>>> rtl/core/bprq_checker.sv
// port-level checks of the burst predicting ready queue
// depends on bprq_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module bprq_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_stall,
    input  bprq_pkg::req_t   req_data,
    input  logic             rsp_valid,
    input  logic             rsp_stall,
    input  bprq_pkg::rsp_t   rsp_data
);
    import bprq_pkg::*;

    logic req_seen;
    assign req_seen = req_valid || req_stall || (req_data.func == FUNC_PICK);

    // stalled result holds
    `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp changed while stalled")

    // a result never carries both a pick outcome and a drop
    `ASSERT_IMPL(a_pick_drop, rsp_valid, !(rsp_data.picked_valid && rsp_data.dropped_full), "pick and drop in one result")

    // a result without a valid pick reports thread zero
    `ASSERT_IMPL(a_empty_pick, rsp_valid && !rsp_data.picked_valid, rsp_data.picked_thread == '0, "empty pick with nonzero thread")

    // accumulated error never goes down
    `ASSERT_IMPL(a_err_mono, rsp_valid && $past(rsp_valid) && req_seen, rsp_data.error_total >= $past(rsp_data.error_total), "error total decreased")

endmodule

bind burst_predicting_ready_queue bprq_checker u_bprq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);

>>> bench/tb.sv
`timescale 1ns / 100ps
// self-checking bench for burst_predicting_ready_queue: directed and random transactions
// with random request gaps and response stalls, checked against a burst-estimate queue predictor
// depends on rtl/core/bprq_pkg.sv and rtl/core/burst_predicting_ready_queue.sv
module tb;

    import bprq_pkg::*;

    // predicted ready queue, estimates and error total, plus the responses still owed
    class ready_queue_scoreboard;
        logic [ID_BITS-1:0]    queued_ids[MAX_THREADS];
        logic [BURST_BITS-1:0] queued_keys[MAX_THREADS];
        int unsigned           queued_count;
        logic [EST_BITS-1:0]   estimates[MAX_THREADS];
        longint unsigned       error_acc;
        logic                  mode;
        logic [WT_BITS-1:0]    weight;
        rsp_t                  owed_responses[$];
        int unsigned           errors;

        function new();
            queued_count = 0;
            error_acc    = 0;
            mode         = MODE_FIFO;
            weight       = WEIGHT_RESET;
            errors       = 0;
            foreach (estimates[i])
            begin
                estimates[i]   = '0;
                queued_ids[i]  = '0;
                queued_keys[i] = '0;
            end
        endfunction

        function void set_register(logic [CFG_IDX_BITS-1:0] index, logic [WT_BITS-1:0] value);
            if (index == REG_POLICY_MODE)
                mode = value[0];
            else if (index == REG_SMOOTHING)
                weight = value;
        endfunction

        function int unsigned pending();
            return owed_responses.size();
        endfunction

        // entries with equal keys keep arrival order; fifo appends at the tail
        function void insert_entry(logic [ID_BITS-1:0] id, logic [BURST_BITS-1:0] key,
                                   bit by_key);
            int unsigned pos;
            pos = queued_count;
            if (by_key)
            begin
                for (int i = 0; i < queued_count; i++)
                begin
                    if (queued_keys[i] > key)
                    begin
                        pos = i;
                        break;
                    end
                end
            end
            for (int i = queued_count; i > pos; i--)
            begin
                queued_ids[i]  = queued_ids[i-1];
                queued_keys[i] = queued_keys[i-1];
            end
            queued_ids[pos]  = id;
            queued_keys[pos] = key;
            queued_count++;
        endfunction

        // advance the predicted state by one accepted transaction
        function void predict_response(req_t req);
            rsp_t            resp;
            longint unsigned est;
            longint unsigned target;
            longint unsigned alpha;
            longint unsigned diff;
            longint unsigned acc_max;
            int unsigned     slot;
            resp    = '0;
            slot    = req.thread_id % MAX_THREADS;
            acc_max = (64'd1 << ACC_BITS) - 1;
            if (req.func == FUNC_PICK)
            begin
                if (queued_count > 0)
                begin
                    resp.picked_thread = queued_ids[0];
                    resp.picked_valid  = 1'b1;
                    for (int i = 1; i < queued_count; i++)
                    begin
                        queued_ids[i-1]  = queued_ids[i];
                        queued_keys[i-1] = queued_keys[i];
                    end
                    queued_count--;
                end
            end
            else if (queued_count >= MAX_THREADS)
            begin
                resp.new_estimate = estimates[slot];
                resp.dropped_full = 1'b1;
            end
            else if (mode == MODE_BURST)
            begin
                est = estimates[slot];
                if (req.prev_burst != 0)
                begin
                    // weights above one are clamped to one
                    alpha  = (weight > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(weight);
                    target = 64'(req.prev_burst) << FRAC_BITS;
                    diff   = (est > target) ? est - target : target - est;
                    est    = (est * (64'(WEIGHT_ONE) - alpha) + target * alpha) >> WT_SHIFT;
                    est    = 64'(EST_BITS'(est));
                    if (acc_max - error_acc < diff)
                        error_acc = acc_max;
                    else
                        error_acc = error_acc + diff;
                    estimates[slot] = EST_BITS'(est);
                end
                insert_entry(req.thread_id, BURST_BITS'(est >> FRAC_BITS), 1'b1);
                resp.new_estimate = EST_BITS'(est);
            end
            else
            begin
                insert_entry(req.thread_id, '0, 1'b0);
                resp.new_estimate = estimates[slot];
            end
            resp.error_total = TOTAL_BITS'(error_acc >> FRAC_BITS);
            owed_responses.push_back(resp);
        endfunction

        // compare an accepted response with the oldest prediction
        function void compare_response(rsp_t got);
            rsp_t want;
            if (owed_responses.size() == 0)
            begin
                $error("response with none outstanding: %h", got);
                errors++;
                return;
            end
            want = owed_responses.pop_front();
            if (got.picked_thread !== want.picked_thread)
            begin
                $error("picked_thread: expected %0d, got %0d", want.picked_thread,
                       got.picked_thread);
                errors++;
            end
            if (got.picked_valid !== want.picked_valid)
            begin
                $error("picked_valid: expected %0d, got %0d", want.picked_valid,
                       got.picked_valid);
                errors++;
            end
            if (got.new_estimate !== want.new_estimate)
            begin
                $error("new_estimate: expected %h, got %h", want.new_estimate,
                       got.new_estimate);
                errors++;
            end
            if (got.dropped_full !== want.dropped_full)
            begin
                $error("dropped_full: expected %0d, got %0d", want.dropped_full,
                       got.dropped_full);
                errors++;
            end
            if (got.error_total !== want.error_total)
            begin
                $error("error_total: expected %h, got %h", want.error_total,
                       got.error_total);
                errors++;
            end
        endfunction
    endclass

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 92;
    localparam int LONG_HOLD_AT = 250;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 6;

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    req_t                     req_data;
    logic                     rsp_valid;
    logic                     rsp_stall;
    rsp_t                     rsp_data;
    logic                     cfg_write;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [WT_BITS-1:0]       cfg_data;

    ready_queue_scoreboard sb = new();
    bit sender_eager;

    burst_predicting_ready_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic req_t make_req(logic func, logic [ID_BITS-1:0] id,
                                      logic [BURST_BITS-1:0] burst);
        req_t req;
        req.func       = func;
        req.thread_id  = id;
        req.prev_burst = burst;
        return req;
    endfunction

    // short bursts and full-range random ones, with zero and the maximum mixed in
    function automatic logic [BURST_BITS-1:0] draw_burst();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return BURST_BITS'($urandom_range(1, 64));
            default: return BURST_BITS'($urandom);
        endcase
    endfunction

    // entered and left at a falling edge; valid stays high for back-to-back transactions
    task automatic send_request(req_t req);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.predict_response(req);
        @(negedge clk);
    endtask

    // hold off the sender until every owed response has arrived
    task automatic drain_responses();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // both registers written while the block is idle
    task automatic apply_settings(logic mode, logic [WT_BITS-1:0] weight);
        drain_responses();
        repeat (SETTLE) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_POLICY_MODE;
        cfg_data  <= WT_BITS'(mode);
        @(posedge clk);
        sb.set_register(REG_POLICY_MODE, WT_BITS'(mode));
        @(negedge clk);
        cfg_index <= REG_SMOOTHING;
        cfg_data  <= weight;
        @(posedge clk);
        sb.set_register(REG_SMOOTHING, weight);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // response side: random stalls, calm stretches, one long hold-off
    initial
    begin
        int results_seen;
        int hold;
        bit rsp_eager;
        results_seen = 0;
        rsp_eager    = 1'b0;
        rsp_stall    = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (results_seen % 50 == 0)
                rsp_eager = ($urandom_range(0, 2) == 0);
            hold = rsp_eager ? 0 : $urandom_range(0, 10);
            if (results_seen == LONG_HOLD_AT)
                hold = LONG_HOLD;
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            sb.compare_response(rsp_data);
            results_seen++;
            @(negedge clk);
        end
    end

    // request side: directed opening, then random phases over several settings
    initial
    begin
        logic phase_mode[PHASES];
        int   phase_weight[PHASES];
        int   ready_pct;
        req_valid    = 1'b0;
        req_data     = '0;
        cfg_write    = 1'b0;
        cfg_index    = REG_POLICY_MODE;
        cfg_data     = '0;
        rst_n        = 1'b0;
        sender_eager = 1'b0;
        phase_mode   = '{MODE_BURST, MODE_FIFO, MODE_BURST, MODE_BURST,
                         MODE_FIFO, MODE_BURST, MODE_BURST, MODE_BURST};
        phase_weight = '{511, 0, 0, 1, 256, 128, 200, $urandom_range(0, 511)};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // fifo at reset settings: empty pick, extreme bursts, same thread twice
        send_request(make_req(FUNC_PICK, 4'd7, 16'd0));
        send_request(make_req(FUNC_READY, 4'd0, 16'd0));
        send_request(make_req(FUNC_READY, 4'd15, 16'hffff));
        send_request(make_req(FUNC_READY, 4'd15, 16'd1));
        send_request(make_req(FUNC_PICK, 4'd0, 16'hffff));
        send_request(make_req(FUNC_PICK, 4'd0, 16'd0));

        // burst mode at full weight; leftover fifo entry keeps key zero at the head
        apply_settings(MODE_BURST, WEIGHT_ONE);
        send_request(make_req(FUNC_READY, 4'd3, 16'hffff));
        send_request(make_req(FUNC_READY, 4'd5, 16'd1));
        send_request(make_req(FUNC_READY, 4'd3, 16'd0));
        // fill the queue with repeated keys, then overflow it
        for (int i = 0; i < 12; i++)
            send_request(make_req(FUNC_READY, ID_BITS'(4 + i), BURST_BITS'(1 + i % 3)));
        send_request(make_req(FUNC_READY, 4'd9, 16'd500));
        send_request(make_req(FUNC_PICK, 4'd0, 16'd0));

        // random phases; the ready share varies so the queue both drains and fills
        for (int p = 0; p < PHASES; p++)
        begin
            apply_settings(phase_mode[p], WT_BITS'(phase_weight[p]));
            ready_pct    = $urandom_range(35, 85);
            sender_eager = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2 && n == 45)
                    drain_responses();
                if ($urandom_range(1, 100) <= ready_pct)
                    send_request(make_req(FUNC_READY, ID_BITS'($urandom), draw_burst()));
                else
                    send_request(make_req(FUNC_PICK, ID_BITS'($urandom), draw_burst()));
            end
        end

        drain_responses();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
